[rtl/rptd_pkg.sv]
package rptd_pkg;

   localparam int          NUM_CHANNELS_DEFAULT = 6;
   localparam logic [15:0] SYNC_GAP_RESET       = 16'd5000;
   localparam logic [2:0]  PPM_SLOT_MAX         = 3'd7;
   localparam logic [15:0] WIDTH_MAX            = 16'hFFFF;
   localparam logic [2:0]  LINE_PPM             = 3'd0;
   localparam logic [2:0]  CH_NONE              = 3'd0;

   typedef struct packed {
      logic        has_edge;
      logic [2:0]  line;
      logic        level;
      logic [31:0] time_us;
      logic [2:0]  query_channel;
   } req_type;

   typedef struct packed {
      logic [2:0]  updated_channel;
      logic [15:0] updated_width;
      logic [15:0] query_width;
   } rsp_type;

endpackage

[rtl/rc_pulse_train_decoder.sv]
// RC receiver pulse decoder: PPM train on line 0, PWM channel lines 1..NUM_CHANNELS.
// req_*: one transfer per edge event or query (valid/stall). Each accepted item
//   gives exactly one rsp_* transfer with the channel it wrote (0 if none), the
//   width written, and the stored width of query_channel after the update.
// csr_*: sync gap in microseconds, written when csr_wr_en is high; the user must
//   write it only while no item is in flight, as the block does not enforce it.
// An accepted item sits in the input register, is decoded and lands in the result
//   register, and rsp_valid is high from then until the transfer. Throughput: one
//   item per cycle while rsp_stall is low; the single subtract / compare / store
//   between the two registers sets it.
// Stall: while rsp_stall holds a result, the item in the input register waits
//   and req_stall rises; state is only updated when an item moves into the
//   result register, so nothing is lost or repeated.
// Reset (synchronous, active high): both stages empty, sync gap back to 5000,
//   PPM slot and last rise time zero, all start times and widths zero.
module rc_pulse_train_decoder
   import rptd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // pipeline control
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    adv2;
   logic    s1_fire;

   // decoder state
   logic [15:0] sync_gap_ff, sync_gap_in;
   logic [31:0] last_ppm_rise_ff, last_ppm_rise_in;
   logic [2:0]  ppm_slot_ff, ppm_slot_in;
   logic [31:0] pwm_rise_time_ff [NUM_CHANNELS];
   logic [31:0] pwm_rise_time_in [NUM_CHANNELS];
   logic [15:0] channel_width_ff [NUM_CHANNELS];
   logic [15:0] channel_width_in [NUM_CHANNELS];

   // decode of the item in the input register
   logic             is_ppm;
   logic             pwm_ok;
   logic [IDX_W-1:0] line_idx;
   logic [31:0]      pwm_base;
   logic [31:0]      rise_base;
   logic [31:0]      dt;
   logic [15:0]      dt_sat;
   logic             ppm_rise;
   logic             pwm_rise;
   logic             pwm_fall;
   logic [2:0]       slot_cur;
   logic             ppm_store;
   logic [2:0]       upd_ch;
   logic [15:0]      upd_w;
   logic [IDX_W-1:0] wr_idx;
   logic             q_ok;
   logic [IDX_W-1:0] q_idx;
   logic [15:0]      q_width;

   // Result register advances when empty or being taken.
   assign adv2      = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && adv2;
   assign req_stall = s1_valid_ff && !adv2;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign s1_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = adv2 ? s1_valid_ff : rsp_valid_ff;
   assign sync_gap_in  = csr_wr_en ? csr_wr_data : sync_gap_ff;

   // Line and channel checks. Indexes are only used when the check passes.
   assign is_ppm   = (s1_data_ff.line == LINE_PPM);
   assign pwm_ok   = !is_ppm && (32'(s1_data_ff.line) <= NUM_CHANNELS);
   assign line_idx = IDX_W'(s1_data_ff.line - 3'd1);
   assign pwm_base = pwm_ok ? pwm_rise_time_ff[line_idx] : '0;

   // One shared subtract: PPM period or PWM high time, modulo 2^32.
   assign rise_base = is_ppm ? last_ppm_rise_ff : pwm_base;
   assign dt        = s1_data_ff.time_us - rise_base;
   assign dt_sat    = (|dt[31:16]) ? WIDTH_MAX : dt[15:0];

   assign ppm_rise = s1_data_ff.has_edge && is_ppm && s1_data_ff.level;
   assign pwm_rise = s1_data_ff.has_edge && pwm_ok && s1_data_ff.level;
   assign pwm_fall = s1_data_ff.has_edge && pwm_ok && !s1_data_ff.level;

   // Long gap restarts the train before the slot is used.
   assign slot_cur  = (ppm_rise && (dt > {16'b0, sync_gap_ff})) ? 3'd0 : ppm_slot_ff;
   assign ppm_store = ppm_rise && (slot_cur != 3'd0) && (slot_cur != PPM_SLOT_MAX)
                      && (32'(slot_cur) <= NUM_CHANNELS);

   always_comb begin
      priority if (ppm_store) begin
         upd_ch = slot_cur;
         upd_w  = dt_sat;
      end else if (pwm_fall) begin
         upd_ch = s1_data_ff.line;
         upd_w  = dt_sat;
      end else begin
         upd_ch = CH_NONE;
         upd_w  = '0;
      end
   end

   assign wr_idx = IDX_W'(upd_ch - 3'd1);

   // Query sees this item's write.
   assign q_ok  = (s1_data_ff.query_channel != CH_NONE)
                  && (32'(s1_data_ff.query_channel) <= NUM_CHANNELS);
   assign q_idx = IDX_W'(s1_data_ff.query_channel - 3'd1);

   always_comb begin
      if (!q_ok) begin
         q_width = '0;
      end else if (upd_ch == s1_data_ff.query_channel) begin
         q_width = upd_w;
      end else begin
         q_width = channel_width_ff[q_idx];
      end
   end

   always_comb begin
      rsp_data_in.updated_channel = upd_ch;
      rsp_data_in.updated_width   = upd_w;
      rsp_data_in.query_width     = q_width;
   end

   // State next values; only an item moving into the result register commits.
   always_comb begin
      last_ppm_rise_in = last_ppm_rise_ff;
      ppm_slot_in      = ppm_slot_ff;
      if (s1_fire && ppm_rise) begin
         last_ppm_rise_in = s1_data_ff.time_us;
         ppm_slot_in      = (slot_cur != PPM_SLOT_MAX) ? slot_cur + 3'd1 : slot_cur;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         pwm_rise_time_in[i] = pwm_rise_time_ff[i];
         channel_width_in[i] = channel_width_ff[i];
         if (s1_fire && pwm_rise && (line_idx == IDX_W'(i))) begin
            pwm_rise_time_in[i] = s1_data_ff.time_us;
         end
         if (s1_fire && (upd_ch != CH_NONE) && (wr_idx == IDX_W'(i))) begin
            channel_width_in[i] = upd_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         sync_gap_ff      <= SYNC_GAP_RESET;
         last_ppm_rise_ff <= '0;
         ppm_slot_ff      <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pwm_rise_time_ff[i] <= '0;
            channel_width_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         sync_gap_ff      <= sync_gap_in;
         last_ppm_rise_ff <= last_ppm_rise_in;
         ppm_slot_ff      <= ppm_slot_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pwm_rise_time_ff[i] <= pwm_rise_time_in[i];
            channel_width_ff[i] <= channel_width_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_data_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTH
   a_no_width_without_channel : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.updated_channel == CH_NONE))
      |-> (rsp_data_ff.updated_width == 16'd0))
      else $error("width reported without a written channel");

   a_channel_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff.updated_channel) <= NUM_CHANNELS))
      else $error("written channel beyond channel count");

   a_slot_after_rise : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && ppm_rise) |=> (ppm_slot_ff != 3'd0))
      else $error("PPM slot zero after a rising edge");

   a_store_matches_result : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (upd_ch != CH_NONE))
      |=> (channel_width_ff[$past(wr_idx)] == rsp_data_ff.updated_width))
      else $error("stored width differs from reported width");
`endif

endmodule

[verif/rc_pulse_train_decoder_tb.sv]
module rc_pulse_train_decoder_tb
   import rptd_pkg::*;
;

   localparam int NUM_CH = NUM_CHANNELS_DEFAULT;

   // ------------------------------------------------------------------
   // Expected-width tracker: mirrors the decoder state and queues one
   // expected rsp transfer per accepted req transfer.
   // ------------------------------------------------------------------
   class decoder_scoreboard;
      logic [15:0] sync_gap;
      logic [31:0] last_ppm_rise;
      logic [2:0]  ppm_slot;
      logic [31:0] rise_time [NUM_CH];
      logic [15:0] width [NUM_CH];
      rsp_type     expected [$];
      int          failures;

      function new();
         sync_gap      = SYNC_GAP_RESET;
         last_ppm_rise = '0;
         ppm_slot      = '0;
         failures      = 0;
         for (int i = 0; i < NUM_CH; i++) begin
            rise_time[i] = '0;
            width[i]     = '0;
         end
      endfunction

      function void set_sync_gap(logic [15:0] gap);
         sync_gap = gap;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function logic [15:0] clip_width(logic [31:0] d);
         return (d > 32'(WIDTH_MAX)) ? WIDTH_MAX : d[15:0];
      endfunction

      // Work out the result of one accepted item and advance the state.
      function void note_request(req_type r);
         rsp_type     want;
         logic [31:0] dt;
         int          k;
         want = '0;
         if (r.has_edge) begin
            if (r.line == LINE_PPM) begin
               // falling edges on the PPM line carry no information
               if (r.level) begin
                  dt            = r.time_us - last_ppm_rise;
                  last_ppm_rise = r.time_us;
                  if (dt > 32'(sync_gap)) ppm_slot = '0;
                  if (ppm_slot >= 1 && ppm_slot < PPM_SLOT_MAX && ppm_slot <= NUM_CH) begin
                     want.updated_channel = ppm_slot;
                     want.updated_width   = clip_width(dt);
                     width[ppm_slot - 1]  = want.updated_width;
                  end
                  if (ppm_slot < PPM_SLOT_MAX) ppm_slot = ppm_slot + 3'd1;
               end
            end else if (r.line <= NUM_CH) begin
               k = int'(r.line) - 1;
               if (r.level) begin
                  rise_time[k] = r.time_us;
               end else begin
                  want.updated_channel = r.line;
                  want.updated_width   = clip_width(r.time_us - rise_time[k]);
                  width[k]             = want.updated_width;
               end
            end
         end
         if (r.query_channel >= 1 && r.query_channel <= NUM_CH)
            want.query_width = width[r.query_channel - 1];
         expected.push_back(want);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected.size() == 0) begin
            $display("%0t: rsp transfer with nothing expected, actual ch %0d width %0d query %0d",
                     $time, got.updated_channel, got.updated_width, got.query_width);
            failures++;
         end else begin
            want = expected.pop_front();
            compare_field("updated_channel", 16'(want.updated_channel),
                          16'(got.updated_channel));
            compare_field("updated_width", want.updated_width, got.updated_width);
            compare_field("query_width", want.query_width, got.query_width);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   rc_pulse_train_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   decoder_scoreboard sb;

   // Idle/stall percentage shared by both sides; zero for the quiet stretch.
   int          idle_pct = 29;
   int          cur_gap  = int'(SYNC_GAP_RESET);

   // Stimulus-side view of the pulse lines, used to build sane trains.
   logic [31:0] ppm_cursor;
   bit          pwm_high [1:NUM_CH];
   logic [31:0] pwm_start [1:NUM_CH];

   // ------------------------------------------------------------------
   // Result side: random stall at the falling edge, check at the rising.
   // ------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic req_type pack_req(bit edge_flag, logic [2:0] line, bit level,
                                        logic [31:0] stamp, logic [2:0] query);
      req_type r;
      r.has_edge      = edge_flag;
      r.line          = line;
      r.level         = level;
      r.time_us       = stamp;
      r.query_channel = query;
      return r;
   endfunction

   // Called and returns at a falling edge. Valid stays high across
   // back-to-back transfers; it only drops for a random idle cycle.
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
      @(negedge clock);
   endtask

   // Let every outstanding result drain, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_sync_gap(input logic [15:0] gap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= gap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_sync_gap(gap);
      cur_gap = int'(gap);
   endtask

   // Mostly well-formed PPM trains and PWM pulse pairs, some query-only
   // items and some fully random noise.
   function automatic req_type next_random_req();
      req_type     r;
      int          pick;
      int          ch;
      logic [31:0] dt;
      r.has_edge      = 1'b1;
      r.line          = LINE_PPM;
      r.level         = 1'b1;
      r.time_us       = $urandom;
      r.query_channel = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 9) == 0) begin
            // falling edge mid-train
            r.level   = 1'b0;
            r.time_us = ppm_cursor + $urandom_range(0, 400);
         end else begin
            // about one sync gap per eight rises, so trains reach slot 7
            if ($urandom_range(0, 7) == 0)
               dt = 32'(cur_gap) + $urandom_range(1, 20000);
            else
               dt = $urandom_range(0, cur_gap);
            ppm_cursor = ppm_cursor + dt;
            r.time_us  = ppm_cursor;
         end
      end else if (pick < 75) begin
         ch     = $urandom_range(1, NUM_CH);
         r.line = 3'(ch);
         if (pwm_high[ch]) begin
            r.level = 1'b0;
            // occasional huge pulse to hit saturation and wrap
            if ($urandom_range(0, 15) == 0) dt = $urandom;
            else dt = $urandom_range(500, 2500);
            r.time_us = pwm_start[ch] + dt;
         end else begin
            pwm_start[ch] = r.time_us;
         end
         pwm_high[ch] = !pwm_high[ch];
      end else if (pick < 85) begin
         // query only; edge fields random and ignored
         r.has_edge = 1'b0;
         r.line     = 3'($urandom_range(0, 7));
         r.level    = 1'($urandom_range(0, 1));
      end else begin
         r.line  = 3'($urandom_range(0, 7));
         r.level = 1'($urandom_range(0, 1));
      end
      return r;
   endfunction

   task automatic run_directed();
      send_item(pack_req(1'b0, 3'd7, 1'b1, 32'hFFFF_FFFF, 3'd0)); // query only, bad channel
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd1000, 3'd1));  // first rise vs time zero
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd2000, 3'd1));  // slot 1
      send_item(pack_req(1'b1, LINE_PPM, 1'b0, 32'd2500, 3'd7));  // PPM falling: ignored
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd3100, 3'd2));
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd4300, 3'd3));
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd5600, 3'd4));
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd7000, 3'd5));
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd8500, 3'd6));  // slot 6
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd10000, 3'd6)); // slot 7: no store
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd15000, 3'd1)); // interval == gap, saturated
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd20001, 3'd1)); // interval gap+1: sync
      send_item(pack_req(1'b1, LINE_PPM, 1'b1, 32'd21000, 3'd1));
      send_item(pack_req(1'b1, 3'd3, 1'b0, 32'd2000, 3'd3));      // fall with no prior rise
      send_item(pack_req(1'b1, 3'd2, 1'b1, 32'hFFFF_FF00, 3'd2));
      send_item(pack_req(1'b1, 3'd2, 1'b0, 32'h0000_0100, 3'd2)); // wraps through zero
      send_item(pack_req(1'b1, 3'd6, 1'b1, 32'd0, 3'd6));
      send_item(pack_req(1'b1, 3'd6, 1'b0, 32'h0010_0000, 3'd6)); // saturates at 65535
      send_item(pack_req(1'b1, 3'd7, 1'b1, 32'd1234, 3'd7));      // unused line
      send_item(pack_req(1'b1, 3'd7, 1'b0, 32'd5678, 3'd0));
      send_item(pack_req(1'b0, LINE_PPM, 1'b1, 32'd0, 3'd5));     // no edge, PPM fields ignored
      send_item(pack_req(1'b1, 3'd4, 1'b1, 32'hFFFF_FFFF, 3'd4));
      send_item(pack_req(1'b1, 3'd4, 1'b0, 32'hFFFF_FFFF, 3'd4)); // zero-width pulse
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [15:0] next_gap;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      for (int i = 1; i <= NUM_CH; i++) begin
         pwm_high[i]  = 1'b0;
         pwm_start[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // Phase 0 runs on the reset gap; the rest write the register first.
      // Phase 2 is the stretch with no idling on either side.
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            case (p)
               1:       next_gap = 16'd0;
               2:       next_gap = 16'hFFFF;
               3:       next_gap = 16'($urandom_range(1000, 9000));
               4:       next_gap = SYNC_GAP_RESET;
               default: next_gap = 16'($urandom);
            endcase
            write_sync_gap(next_gap);
         end
         idle_pct   = (p == 2) ? 0 : 29;
         // one phase starts just below the 32-bit wrap
         ppm_cursor = (p == 3) ? 32'hFFFF_8000 : $urandom;
         repeat (300) send_item(next_random_req());
      end

      wait_idle();
      repeat (6) @(negedge clock);
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[rc_pulse_train_decoder.f]
rtl/rptd_pkg.sv
rtl/rc_pulse_train_decoder.sv
verif/rc_pulse_train_decoder_tb.sv
